// ----- rtl/core/histogram_entropy_top_defines.svh -----
// Assertion macros used by the RTL of the histogram entropy block.
`ifndef HISTOGRAM_ENTROPY_TOP_DEFINES_SVH
`define HISTOGRAM_ENTROPY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/core/hent_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hent_pkg;

	localparam int MAX_BINS   = 1024;
	localparam int FRAC_BITS  = 24;

	localparam int BIN_W      = 24;
	localparam int ENT_W      = 30;
	localparam int TOT_W      = 34;
	localparam int SUM_W      = 64;
	localparam int BINS_W     = $clog2(MAX_BINS + 1);
	localparam int POS_W      = $clog2(TOT_W);
	localparam int NORM_STEPS = POS_W;
	localparam int STEP_W     = $clog2(NORM_STEPS);
	localparam int CNT_W      = $clog2(FRAC_BITS + 1);
	localparam int LOG_W      = POS_W + FRAC_BITS;
	localparam int MANT_W     = 32;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DCNT_W     = $clog2(SUM_W);

	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOG,
		ST_MULC,
		ST_ACC,
		ST_FINAL,
		ST_DIVWAIT,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [TOT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic q_valid;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/hent_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hent_mul (
	input  wire                    clk,
	input  wire hent_pkg::mul_req_t req,
	output logic [hent_pkg::PROD_W-1:0] prod
);
	import hent_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= {{(PROD_W-MUL_W){1'b0}}, req.a} * {{(PROD_W-MUL_W){1'b0}}, req.b};
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ----- rtl/core/hent_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hent_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire hent_pkg::div_req_t      req,
	output hent_pkg::div_stat_t          stat,
	output logic [hent_pkg::SUM_W-1:0]   quot
);
	import hent_pkg::*;

	logic              busy_q;
	logic              qv_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  dvs_q;
	logic [TOT_W:0]    trial;
	logic [TOT_W:0]    diff;
	logic              ge;

	// One quotient bit per cycle by restoring division.
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			qv_q   <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			qv_q   <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				qv_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

	assign stat.busy    = busy_q;
	assign stat.q_valid = qv_q;
	assign quot         = dvd_q;

endmodule

`default_nettype wire

// ----- rtl/core/histogram_entropy_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_entropy_top_defines.svh"

// Channel   Direction  Payload                                    Transfer when
// s_*       in         tdata = bin_count, tlast = last_bin        s_tvalid && s_tready
// m_*       out        tdata = entropy_q24, tuser = flags         m_tvalid && m_tready
//
// A bin with a count of 0 or 1, or one beyond the bin limit, is taken without a log evaluation.
// A larger count goes through six normalising shift steps, one squaring per fraction bit
// on the shared 32 x 32 multiplier, then one multiply and one accumulate.
// After the last bin, the 64-step divider runs beside the log of the total. The
// asynchronous reset clears all accumulators and the valid flag of the output slot.
// The input is ready only while the sequencer idles; a result waiting on a stalled
// output blocks the next result but not the bins that come before it.

module histogram_entropy_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [hent_pkg::S_TDATA_W-1:0]     s_tdata,  // [23:0] bin_count
	input  wire                                s_tlast,  // last_bin
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [hent_pkg::M_TDATA_W-1:0]     m_tdata,  // [29:0] entropy_q24, [31:30] zero
	output logic [hent_pkg::M_TUSER_W-1:0]     m_tuser   // [0] total_was_zero, [1] bin_overflow
);
	import hent_pkg::*;

	// Sequencer state and the accumulators of the current histogram.
	seq_state_t        state_q, state_nxt;
	logic [TOT_W-1:0]  tot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BINS_W-1:0] bins_q;
	logic              ovf_q;
	logic              last_q;
	logic              tot_sel_q;

	// Working registers of the log evaluation.
	logic [BIN_W-1:0]     c_q;
	logic [TOT_W-1:0]     x_q;
	logic [POS_W-1:0]     lz_q;
	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [ENT_W-1:0]     res_ent_q;
	logic                 res_zero_q;

	// Output slot.
	logic             m_tvalid_q;
	logic [ENT_W-1:0] out_ent_q;
	logic             out_zero_q;
	logic             out_ovf_q;

	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;
	div_req_t          div_req;
	div_stat_t         div_stat;
	logic [SUM_W-1:0]  quot;

	logic              accept;
	logic              bins_full;
	logic              out_free;
	logic              emit_load;
	logic [POS_W-1:0]  shamt;
	logic              hi_zero;
	logic [LOG_W-1:0]  lg;
	logic [MANT_W-1:0] mant_init;
	logic [MANT_W-1:0] mant_next;
	logic [ENT_W-1:0]  ent_val;

	hent_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	hent_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quot   (quot)
	);

	assign accept    = s_tvalid && s_tready;
	assign bins_full = (bins_q >= BINS_W'(MAX_BINS));
	assign out_free  = !m_tvalid_q || m_tready;

	// Binary search for the leading one: each step tries a shift half the size of the last.
	assign shamt   = POS_W'(1) << (STEP_W'(NORM_STEPS - 1) - step_q);
	assign hi_zero = ((x_q >> (TOT_W - int'(shamt))) == '0);

	// Once the top bit sits at the word's MSB, the mantissa is the top 32 bits; the
	// integer part of the log is the leading-one position.
	assign lg        = {POS_W'(TOT_W - 1) - lz_q, frac_q};
	assign mant_init = x_q[TOT_W-1 -: MANT_W];

	// A square of 2.0 or more shows as the product's top bit; the mantissa is then halved.
	assign mant_next = prod[PROD_W-1] ? prod[PROD_W-1 -: MANT_W] : prod[PROD_W-2 -: MANT_W];

	// Entropy is log2(N) minus the truncated quotient, clamped at zero.
	assign ent_val = (quot > SUM_W'(lg)) ? '0 : (ENT_W'(lg) - ENT_W'(quot));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (!bins_full && (s_tdata > S_TDATA_W'(1))) begin
						state_nxt = ST_NORM;
					end else begin
						state_nxt = s_tlast ? ST_FINAL : ST_IDLE;
					end
				end
			end
			ST_NORM: begin
				if (step_q == STEP_W'(NORM_STEPS - 1)) begin
					state_nxt = ST_LOG;
				end
			end
			ST_LOG: begin
				if (cnt_q == CNT_W'(FRAC_BITS)) begin
					state_nxt = tot_sel_q ? ST_DIVWAIT : ST_MULC;
				end
			end
			ST_MULC: begin
				state_nxt = ST_ACC;
			end
			ST_ACC: begin
				state_nxt = last_q ? ST_FINAL : ST_IDLE;
			end
			ST_FINAL: begin
				state_nxt = (tot_q == '0) ? ST_EMIT : ST_NORM;
			end
			ST_DIVWAIT: begin
				if (div_stat.q_valid) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		emit_load        = 1'b0;
		mul_req.en       = 1'b0;
		mul_req.a        = mant_init;
		mul_req.b        = mant_init;
		div_req.start    = 1'b0;
		div_req.dividend = sum_q;
		div_req.divisor  = tot_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_LOG: begin
				mul_req.en = (cnt_q != CNT_W'(FRAC_BITS));
				if (cnt_q != '0) begin
					mul_req.a = mant_next;
					mul_req.b = mant_next;
				end
			end
			ST_MULC: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_W'(c_q);
				mul_req.b  = MUL_W'(lg);
			end
			ST_FINAL: begin
				div_req.start = (tot_q != '0);
			end
			ST_EMIT: begin
				emit_load = out_free;
			end
			ST_NORM, ST_ACC, ST_DIVWAIT: begin
				s_tready = 1'b0;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tot_q      <= '0;
			sum_q      <= '0;
			bins_q     <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			tot_sel_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q    <= s_tlast;
				tot_sel_q <= 1'b0;
				if (bins_full) begin
					ovf_q <= 1'b1;
				end else begin
					bins_q <= bins_q + 1'b1;
					tot_q  <= tot_q + TOT_W'(s_tdata);
				end
			end
			if (state_q == ST_ACC) begin
				sum_q <= sum_q + prod;
			end
			if (state_q == ST_FINAL) begin
				tot_sel_q <= 1'b1;
			end
			if (emit_load) begin
				tot_q      <= '0;
				sum_q      <= '0;
				bins_q     <= '0;
				ovf_q      <= 1'b0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= s_tdata;
			x_q    <= TOT_W'(s_tdata);
			lz_q   <= '0;
			step_q <= '0;
		end
		if (state_q == ST_NORM) begin
			if (hi_zero) begin
				x_q  <= x_q << shamt;
				lz_q <= lz_q + shamt;
			end
			step_q <= step_q + 1'b1;
			cnt_q  <= '0;
		end
		if (state_q == ST_LOG) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q != '0) begin
				frac_q <= {frac_q[FRAC_BITS-2:0], prod[PROD_W-1]};
			end
		end
		if (state_q == ST_FINAL) begin
			x_q        <= tot_q;
			lz_q       <= '0;
			step_q     <= '0;
			res_ent_q  <= '0;
			res_zero_q <= (tot_q == '0);
		end
		if ((state_q == ST_DIVWAIT) && div_stat.q_valid) begin
			res_ent_q <= ent_val;
		end
		if (emit_load) begin
			out_ent_q  <= res_ent_q;
			out_zero_q <= res_zero_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(out_ent_q);
	assign m_tuser  = {out_ovf_q, out_zero_q};

	// The bin counter saturates at the limit; later bins only raise the overflow flag.
	`HE_ASSERT_IMP(a_bins_bounded, clk, arst_n, 1'b1, bins_q <= BINS_W'(MAX_BINS))
	// The sequencer waits on the divider only after having started it.
	`HE_ASSERT_IMP(a_divwait_started, clk, arst_n, state_q == ST_DIVWAIT, div_stat.busy || div_stat.q_valid)
	// Loading the output slot registers the result as valid, returns the sequencer to idle and clears the total.
	`HE_ASSERT_NEXT(a_emit_loads, clk, arst_n, emit_load, m_tvalid && (state_q == ST_IDLE) && (tot_q == '0))
	// An empty histogram always reports zero entropy.
	`HE_ASSERT_IMP(a_empty_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule

`default_nettype wire
